FILE: src/hpt_pkg.sv
// hpt_pkg: widths, register indexes and shared types of the projective point transform
// used by every module of the block; depends on nothing

package hpt_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam int COORD_W    = 32;
  localparam int PROD_W     = 2 * COORD_W;
  localparam int SUM_W      = PROD_W + 2;
  localparam int REM_W      = SUM_W;
  localparam int QBITS      = COORD_W + 1;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 64;

  localparam logic [COORD_W-1:0] COORD_MAX = 32'h7FFF_FFFF;
  localparam logic [COORD_W-1:0] COORD_MIN = 32'h8000_0000;

  localparam logic [CFG_IDX_W-1:0] REG_SCALE_XX       = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHEAR_YX       = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X       = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHEAR_XY       = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_YY       = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y       = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PROJECTIVE     = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_OFFSET  = 4'd7;

  typedef struct packed {
    logic [COORD_W-1:0] scale_xx;
    logic [COORD_W-1:0] shear_yx;
    logic [COORD_W-1:0] offset_x;
    logic [COORD_W-1:0] shear_xy;
    logic [COORD_W-1:0] scale_yy;
    logic [COORD_W-1:0] offset_y;
    logic [COORD_W-1:0] proj_x;
    logic [COORD_W-1:0] proj_y;
    logic [COORD_W-1:0] weight_offset;
  } cfg_t;

  typedef struct packed {
    logic [REM_W-1:0] rem_x;
    logic [REM_W-1:0] rem_y;
    logic [QBITS-1:0] low_x;
    logic [QBITS-1:0] low_y;
    logic [QBITS-1:0] q_x;
    logic [QBITS-1:0] q_y;
    logic [REM_W-1:0] den;
    logic             neg_x;
    logic             neg_y;
    logic             big_x;
    logic             big_y;
    logic             zero;
  } div_data_t;

  typedef struct packed {
    logic [COORD_W-1:0] result_x;
    logic [COORD_W-1:0] result_y;
    logic               zero_weight;
    logic               overflowed;
  } result_t;

endpackage

FILE: src/hpt_affine.sv
// hpt_affine: three-stage multiply and sum of the two numerators and the denominator
// depends on hpt_pkg

module hpt_affine #(
  parameter int FRAC_BITS = hpt_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic [hpt_pkg::COORD_W-1:0]       point_x,
  input  logic [hpt_pkg::COORD_W-1:0]       point_y,
  input  hpt_pkg::cfg_t                     cfg,
  output logic                              out_valid,
  output logic signed [hpt_pkg::SUM_W-1:0]  num_x,
  output logic signed [hpt_pkg::SUM_W-1:0]  num_y,
  output logic signed [hpt_pkg::SUM_W-1:0]  den
);
  import hpt_pkg::*;

  logic signed [PROD_W-1:0] p_xx, p_yx, p_xy, p_yy, p_px, p_py;
  logic signed [SUM_W-1:0]  sum_x, sum_y, sum_w;
  logic signed [SUM_W-1:0]  off_x, off_y, off_w;
  logic                     valid_a, valid_b;

  assign off_x = SUM_W'($signed(cfg.offset_x)) <<< FRAC_BITS;
  assign off_y = SUM_W'($signed(cfg.offset_y)) <<< FRAC_BITS;
  assign off_w = SUM_W'($signed(cfg.weight_offset)) <<< FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a   <= 1'b0;
      valid_b   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      valid_a   <= in_valid;
      valid_b   <= valid_a;
      out_valid <= valid_b;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_xx  <= $signed(point_x) * $signed(cfg.scale_xx);
      p_yx  <= $signed(point_y) * $signed(cfg.shear_yx);
      p_xy  <= $signed(point_x) * $signed(cfg.shear_xy);
      p_yy  <= $signed(point_y) * $signed(cfg.scale_yy);
      p_px  <= $signed(point_x) * $signed(cfg.proj_x);
      p_py  <= $signed(point_y) * $signed(cfg.proj_y);
      sum_x <= SUM_W'(p_xx) + SUM_W'(p_yx);
      sum_y <= SUM_W'(p_xy) + SUM_W'(p_yy);
      sum_w <= SUM_W'(p_px) + SUM_W'(p_py);
      num_x <= sum_x + off_x;
      num_y <= sum_y + off_y;
      den   <= sum_w + off_w;
    end
  end

endmodule

FILE: src/hpt_div_step.sv
// hpt_div_step: one registered restoring-division step for both quotient lanes
// depends on hpt_pkg

module hpt_div_step (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  hpt_pkg::div_data_t   in_data,
  output logic                 out_valid,
  output hpt_pkg::div_data_t   out_data
);
  import hpt_pkg::*;

  function automatic logic [REM_W:0] restore(logic [REM_W-1:0] rem, logic in_bit,
                                             logic [REM_W-1:0] divisor);
    logic [REM_W:0] trial;
    trial = {rem, in_bit};
    if (trial >= {1'b0, divisor}) begin
      restore = {1'b1, REM_W'(trial - {1'b0, divisor})};
    end else begin
      restore = {1'b0, trial[REM_W-1:0]};
    end
  endfunction

  logic [REM_W:0] step_x, step_y;
  div_data_t      data_next;

  always_comb begin
    step_x          = restore(in_data.rem_x, in_data.low_x[QBITS-1], in_data.den);
    step_y          = restore(in_data.rem_y, in_data.low_y[QBITS-1], in_data.den);
    data_next       = in_data;
    data_next.rem_x = step_x[REM_W-1:0];
    data_next.rem_y = step_y[REM_W-1:0];
    data_next.low_x = {in_data.low_x[QBITS-2:0], 1'b0};
    data_next.low_y = {in_data.low_y[QBITS-2:0], 1'b0};
    data_next.q_x   = {in_data.q_x[QBITS-2:0], step_x[REM_W]};
    data_next.q_y   = {in_data.q_y[QBITS-2:0], step_y[REM_W]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= data_next;
    end
  end

endmodule

FILE: src/hpt_divider.sv
// hpt_divider: pipelined signed divide of both numerators by the denominator, with saturation
// depends on hpt_pkg and hpt_div_step

module hpt_divider #(
  parameter int FRAC_BITS = hpt_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic signed [hpt_pkg::SUM_W-1:0]  num_x,
  input  logic signed [hpt_pkg::SUM_W-1:0]  num_y,
  input  logic signed [hpt_pkg::SUM_W-1:0]  den,
  output logic                              out_valid,
  output hpt_pkg::result_t                  out_data
);
  import hpt_pkg::*;

  localparam int NW = SUM_W + FRAC_BITS;
  localparam logic [QBITS-1:0] POS_LIMIT = QBITS'(COORD_MAX);
  localparam logic [QBITS-1:0] NEG_LIMIT = QBITS'(COORD_MIN);

  // returns {saturated, value}
  function automatic logic [COORD_W:0] finish(logic [QBITS-1:0] q, logic big, logic neg);
    if (neg) begin
      if (big || q > NEG_LIMIT) begin
        finish = {1'b1, COORD_MIN};
      end else begin
        finish = {1'b0, -q[COORD_W-1:0]};
      end
    end else begin
      if (big || q > POS_LIMIT) begin
        finish = {1'b1, COORD_MAX};
      end else begin
        finish = {1'b0, q[COORD_W-1:0]};
      end
    end
  endfunction

  logic [REM_W-1:0] abs_x, abs_y, abs_d;
  logic             neg_x, neg_y, zero;
  logic             valid_p;
  logic [NW-1:0]    full_x, full_y;
  logic [REM_W-1:0] hi_x, hi_y;
  div_data_t        prep_data;
  logic             valid_first;
  div_data_t        data_first;

  div_data_t        stage_data  [QBITS+1];
  logic             stage_valid [QBITS+1];

  logic [COORD_W:0] fin_x, fin_y;
  div_data_t        last;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_p     <= 1'b0;
      valid_first <= 1'b0;
      out_valid   <= 1'b0;
    end else if (en) begin
      valid_p     <= in_valid;
      valid_first <= valid_p;
      out_valid   <= stage_valid[QBITS];
    end
  end

  // sign and magnitude
  always_ff @(posedge clk) begin
    if (en) begin
      abs_x <= num_x[SUM_W-1] ? $unsigned(-num_x) : $unsigned(num_x);
      abs_y <= num_y[SUM_W-1] ? $unsigned(-num_y) : $unsigned(num_y);
      abs_d <= den[SUM_W-1] ? $unsigned(-den) : $unsigned(den);
      neg_x <= num_x[SUM_W-1] ^ den[SUM_W-1];
      neg_y <= num_y[SUM_W-1] ^ den[SUM_W-1];
      zero  <= (den == '0);
    end
  end

  // scaled dividend split into the part above the quotient bits and the bits still to shift in
  always_comb begin
    full_x          = {abs_x, {FRAC_BITS{1'b0}}};
    full_y          = {abs_y, {FRAC_BITS{1'b0}}};
    hi_x            = REM_W'(full_x >> QBITS);
    hi_y            = REM_W'(full_y >> QBITS);
    prep_data.rem_x = hi_x;
    prep_data.rem_y = hi_y;
    prep_data.low_x = full_x[QBITS-1:0];
    prep_data.low_y = full_y[QBITS-1:0];
    prep_data.q_x   = '0;
    prep_data.q_y   = '0;
    prep_data.den   = abs_d;
    prep_data.neg_x = neg_x;
    prep_data.neg_y = neg_y;
    prep_data.big_x = (hi_x >= abs_d);
    prep_data.big_y = (hi_y >= abs_d);
    prep_data.zero  = zero;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_first <= prep_data;
    end
  end

  assign stage_valid[0] = valid_first;
  assign stage_data[0]  = data_first;

  for (genvar i = 0; i < QBITS; i++) begin : g_step
    hpt_div_step u_step (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (stage_valid[i]),
      .in_data   (stage_data[i]),
      .out_valid (stage_valid[i+1]),
      .out_data  (stage_data[i+1])
    );
  end

  always_comb begin
    last  = stage_data[QBITS];
    fin_x = finish(last.q_x, last.big_x, last.neg_x);
    fin_y = finish(last.q_y, last.big_y, last.neg_y);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (last.zero) begin
        out_data.result_x    <= '0;
        out_data.result_y    <= '0;
        out_data.zero_weight <= 1'b1;
        out_data.overflowed  <= 1'b0;
      end else begin
        out_data.result_x    <= fin_x[COORD_W-1:0];
        out_data.result_y    <= fin_y[COORD_W-1:0];
        out_data.zero_weight <= 1'b0;
        out_data.overflowed  <= fin_x[COORD_W] | fin_y[COORD_W];
      end
    end
  end

endmodule

FILE: src/hpt_skid.sv
// hpt_skid: output register with a skid entry; its registered ready advances the pipeline
// depends on hpt_pkg

module hpt_skid (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  hpt_pkg::result_t  in_data,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output hpt_pkg::result_t  out_data
);
  import hpt_pkg::*;

  result_t skid_data;
  logic    skid_valid;
  logic    take_in;

  assign in_ready = !skid_valid;
  assign take_in  = in_valid && !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= take_in;
      end
    end else if (take_in) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (take_in) begin
        out_data <= in_data;
      end
    end else if (take_in) begin
      skid_data <= in_data;
    end
  end

endmodule

FILE: src/homogeneous_point_transform_2d_unit.sv
// homogeneous_point_transform_2d_unit: top level with configuration registers and the pipeline
// depends on hpt_pkg, hpt_affine, hpt_divider and hpt_skid
//
// Usage:
//   cfg channel: one request writes register cfg_index with cfg_data; cfg_ready is always
//   high, unknown indexes are dropped, 32-bit registers keep the low 32 data bits, and the
//   projective pair takes the x weight from bits 31:0 and the y weight from bits 63:32.
//   Write only while no point is in flight.
//   s_axis: one point per request, tdata holds point_x (31:0) and point_y (63:32).
//   m_axis: one result per point in order, tdata holds result_x and result_y,
//   tuser holds zero_weight (bit 0) and overflowed (bit 1).
//   Path from an accepted point to m_axis_tvalid: three multiply and sum
//   stages, two divider set-up stages, 33 division steps, one saturation stage and the
//   output register.
//   Throughput: one point per cycle when not stalled; one quotient bit per divider stage.
//   Stall: a held m_axis_tready freezes the whole pipeline as soon as the output and
//   skid registers both hold a result; s_axis_tready comes from a register and drops with it.
//   Reset: empties the pipeline and loads the identity transform.

module homogeneous_point_transform_2d_unit #(
  parameter int FRAC_BITS = hpt_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [hpt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hpt_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [2*hpt_pkg::COORD_W-1:0]    s_axis_tdata,   // point_x, point_y
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [2*hpt_pkg::COORD_W-1:0]    m_axis_tdata,   // result_x, result_y
  output logic [1:0]                       m_axis_tuser    // zero_weight, overflowed
);
  import hpt_pkg::*;

  localparam logic [COORD_W-1:0] UNITY = COORD_W'(64'd1 << FRAC_BITS);

  cfg_t                     cfg;
  logic                     en;
  logic                     aff_valid;
  logic signed [SUM_W-1:0]  num_x, num_y, den;
  logic                     div_valid;
  result_t                  div_data;
  result_t                  out_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scale_xx      <= UNITY;
      cfg.shear_yx      <= '0;
      cfg.offset_x      <= '0;
      cfg.shear_xy      <= '0;
      cfg.scale_yy      <= UNITY;
      cfg.offset_y      <= '0;
      cfg.proj_x        <= '0;
      cfg.proj_y        <= '0;
      cfg.weight_offset <= UNITY;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SCALE_XX:      cfg.scale_xx      <= cfg_data[COORD_W-1:0];
        REG_SHEAR_YX:      cfg.shear_yx      <= cfg_data[COORD_W-1:0];
        REG_OFFSET_X:      cfg.offset_x      <= cfg_data[COORD_W-1:0];
        REG_SHEAR_XY:      cfg.shear_xy      <= cfg_data[COORD_W-1:0];
        REG_SCALE_YY:      cfg.scale_yy      <= cfg_data[COORD_W-1:0];
        REG_OFFSET_Y:      cfg.offset_y      <= cfg_data[COORD_W-1:0];
        REG_PROJECTIVE: begin
          cfg.proj_x <= cfg_data[COORD_W-1:0];
          cfg.proj_y <= cfg_data[2*COORD_W-1:COORD_W];
        end
        REG_WEIGHT_OFFSET: cfg.weight_offset <= cfg_data[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = en;

  hpt_affine #(
    .FRAC_BITS (FRAC_BITS)
  ) u_affine (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_axis_tvalid),
    .point_x   (s_axis_tdata[COORD_W-1:0]),
    .point_y   (s_axis_tdata[2*COORD_W-1:COORD_W]),
    .cfg       (cfg),
    .out_valid (aff_valid),
    .num_x     (num_x),
    .num_y     (num_y),
    .den       (den)
  );

  hpt_divider #(
    .FRAC_BITS (FRAC_BITS)
  ) u_divider (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (aff_valid),
    .num_x     (num_x),
    .num_y     (num_y),
    .den       (den),
    .out_valid (div_valid),
    .out_data  (div_data)
  );

  hpt_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (div_valid),
    .in_data   (div_data),
    .in_ready  (en),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_data)
  );

  assign m_axis_tdata = {out_data.result_y, out_data.result_x};
  assign m_axis_tuser = {out_data.overflowed, out_data.zero_weight};

endmodule

FILE: tb/sv/tb.sv
// tb: self-checking bench for homogeneous_point_transform_2d_unit, predicts each point in place
// depends on hpt_pkg and the unit; drives stream and register ports, checks results in order

module tb;
  import hpt_pkg::*;

  localparam int NUM_REGS = 8;
  localparam int RANDOM_PHASES = 9;
  localparam int POINTS_PER_PHASE = 125;
  localparam int PRESSURE_PHASE = 4;
  localparam int HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 60;
  localparam logic [COORD_W-1:0] UNITY = COORD_W'(1) << FRAC_BITS_DEF;
  localparam logic [COORD_W-1:0] NEG_UNITY = ~UNITY + 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_BEYOND_FIRST = CFG_IDX_W'(NUM_REGS);
  localparam logic [CFG_IDX_W-1:0] REG_BEYOND_LAST = '1;

  typedef logic signed [127:0] wide_t;
  typedef enum logic [1:0] {CFG_FULL_RANDOM, CFG_NEAR_AFFINE, CFG_HORIZON, CFG_SPARSE} cfg_style_t;
  typedef enum logic [1:0] {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_PERIODIC} ready_mode_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [CFG_DATA_W-1:0]      cfg_data = '0;
  logic                       s_axis_tvalid = 1'b0;
  logic                       s_axis_tready;
  logic [2*COORD_W-1:0]       s_axis_tdata = '0;   // point_x, point_y
  logic                       m_axis_tvalid;
  logic                       m_axis_tready = 1'b0;
  logic [2*COORD_W-1:0]       m_axis_tdata;        // result_x, result_y
  logic [1:0]                 m_axis_tuser;        // zero_weight, overflowed

  homogeneous_point_transform_2d_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // matrix as the block should hold it
  logic signed [COORD_W-1:0] mat_sxx, mat_syx, mat_ox, mat_sxy, mat_syy, mat_oy;
  logic signed [COORD_W-1:0] mat_px, mat_py, mat_w0;

  logic [2*COORD_W-1:0] points_to_send[$];
  result_t              projected_points[$];
  result_t              due;
  logic                 point_fire = 1'b0;
  int                   error_count = 0;

  logic                 no_gaps = 1'b0;
  int                   burst_left = 0;
  int                   gap_left = 0;

  int                   hold_requests = 0;
  int                   holds_served = 0;
  int                   hold_left = 0;
  int                   mode_left = 0;
  int                   rx_tick = 0;
  ready_mode_t          ready_mode = READY_ALWAYS;

  int                   idle_cycles = 0;

  logic                 horizon_mode = 1'b0;
  int                   hz_py = 0;
  int                   hz_w0 = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic wide_t weighted_sum(input logic signed [COORD_W-1:0] c0, c1, c2, x, y);
    wide_t a0, a1, a2, bx, by;
    a0 = c0;
    a1 = c1;
    a2 = c2;
    bx = x;
    by = y;
    return a0 * bx + a1 * by + (a2 <<< FRAC_BITS_DEF);
  endfunction

  // {saturated, quotient} of num * 2^frac / den, truncated toward zero
  function automatic logic [COORD_W:0] divide_saturate(input wide_t num, input wide_t den);
    logic         neg;
    logic [127:0] n, d, q;
    neg = num[127] ^ den[127];
    n = num[127] ? -num : num;
    d = den[127] ? -den : den;
    q = (n << FRAC_BITS_DEF) / d;
    if (q == 0) return '0;
    if (!neg) begin
      if (q > 128'h7FFF_FFFF) return {1'b1, COORD_MAX};
      return {1'b0, q[COORD_W-1:0]};
    end
    if (q > 128'h8000_0000) return {1'b1, COORD_MIN};
    return {1'b0, -q[COORD_W-1:0]};
  endfunction

  function automatic result_t project_point(input logic signed [COORD_W-1:0] x, y);
    result_t          r;
    wide_t            w;
    logic [COORD_W:0] qx, qy;
    r = '0;
    w = weighted_sum(mat_px, mat_py, mat_w0, x, y);
    if (w == 0) begin
      r.zero_weight = 1'b1;
      return r;
    end
    qx = divide_saturate(weighted_sum(mat_sxx, mat_syx, mat_ox, x, y), w);
    qy = divide_saturate(weighted_sum(mat_sxy, mat_syy, mat_oy, x, y), w);
    r.result_x = qx[COORD_W-1:0];
    r.result_y = qy[COORD_W-1:0];
    r.overflowed = qx[COORD_W] | qy[COORD_W];
    return r;
  endfunction

  // monitor: register writes, accepted points and results
  always @(posedge clk) begin
    if (rst) begin
      mat_sxx = UNITY;
      mat_syx = '0;
      mat_ox = '0;
      mat_sxy = '0;
      mat_syy = UNITY;
      mat_oy = '0;
      mat_px = '0;
      mat_py = '0;
      mat_w0 = UNITY;
      projected_points.delete();
      point_fire <= 1'b0;
    end else begin
      point_fire <= s_axis_tvalid && s_axis_tready;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SCALE_XX:      mat_sxx = cfg_data[COORD_W-1:0];
          REG_SHEAR_YX:      mat_syx = cfg_data[COORD_W-1:0];
          REG_OFFSET_X:      mat_ox = cfg_data[COORD_W-1:0];
          REG_SHEAR_XY:      mat_sxy = cfg_data[COORD_W-1:0];
          REG_SCALE_YY:      mat_syy = cfg_data[COORD_W-1:0];
          REG_OFFSET_Y:      mat_oy = cfg_data[COORD_W-1:0];
          REG_PROJECTIVE: begin
            mat_px = cfg_data[COORD_W-1:0];
            mat_py = cfg_data[2*COORD_W-1:COORD_W];
          end
          REG_WEIGHT_OFFSET: mat_w0 = cfg_data[COORD_W-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        projected_points.push_back(project_point(s_axis_tdata[COORD_W-1:0],
                                                 s_axis_tdata[2*COORD_W-1:COORD_W]));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (projected_points.size() == 0) begin
          $error("result with no point outstanding: tdata %h tuser %b", m_axis_tdata,
                 m_axis_tuser);
          error_count++;
        end else begin
          due = projected_points.pop_front();
          if (m_axis_tdata[COORD_W-1:0] !== due.result_x) begin
            $error("result_x mismatch: expected %h, got %h", due.result_x,
                   m_axis_tdata[COORD_W-1:0]);
            error_count++;
          end
          if (m_axis_tdata[2*COORD_W-1:COORD_W] !== due.result_y) begin
            $error("result_y mismatch: expected %h, got %h", due.result_y,
                   m_axis_tdata[2*COORD_W-1:COORD_W]);
            error_count++;
          end
          if (m_axis_tuser[0] !== due.zero_weight) begin
            $error("zero_weight mismatch: expected %b, got %b", due.zero_weight,
                   m_axis_tuser[0]);
            error_count++;
          end
          if (m_axis_tuser[1] !== due.overflowed) begin
            $error("overflowed mismatch: expected %b, got %b", due.overflowed,
                   m_axis_tuser[1]);
            error_count++;
          end
        end
      end
    end
  end

  // point sender: bursts with random gaps
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || point_fire) begin
      if (gap_left > 0 && !no_gaps) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (points_to_send.size() > 0) begin
        s_axis_tdata <= points_to_send.pop_front();
        s_axis_tvalid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 :
                     $urandom_range(1, ($urandom_range(0, 3) == 0) ? 25 : 4);
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result receiver: changing stall patterns plus long hold-offs on request
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (holds_served != hold_requests) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        ready_mode = ready_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 200);
      end else begin
        mode_left--;
      end
      rx_tick++;
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case (ready_mode)
          READY_ALWAYS: m_axis_tready <= 1'b1;
          READY_COIN:   m_axis_tready <= $urandom_range(0, 1);
          READY_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
          default:      m_axis_tready <= (rx_tick % 8) < 5;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic end_writes;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_point(input logic [COORD_W-1:0] x, y);
    points_to_send.push_back({y, x});
  endtask

  task automatic wait_idle;
    @(posedge clk);
    while (points_to_send.size() != 0 || s_axis_tvalid || projected_points.size() != 0)
      @(posedge clk);
  endtask

  function automatic logic [COORD_W-1:0] small_coeff();
    return $urandom_range(0, 524288) - 262144;
  endfunction

  function automatic logic [COORD_W-1:0] edge_coeff();
    case ($urandom_range(0, 6))
      0:       return COORD_MIN;
      1:       return COORD_MAX;
      2:       return '0;
      3:       return UNITY;
      4:       return NEG_UNITY;
      5:       return COORD_W'(1);
      default: return '1;
    endcase
  endfunction

  function automatic logic [COORD_W-1:0] any_coeff();
    case ($urandom_range(0, 4))
      0, 1, 2: return $urandom;
      3:       return edge_coeff();
      default: return small_coeff();
    endcase
  endfunction

  function automatic logic [2*COORD_W-1:0] random_point();
    logic [COORD_W-1:0] x, y;
    int                 k;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        x = $urandom;
        y = $urandom;
      end
      4, 5, 6: begin
        x = $urandom_range(0, 2097152) - 1048576;
        y = $urandom_range(0, 2097152) - 1048576;
      end
      7: begin
        x = edge_coeff();
        y = edge_coeff();
      end
      default: begin
        if (horizon_mode) begin
          // lands on the line where the denominator vanishes
          k = int'($urandom_range(0, 16)) - 8;
          y = k <<< FRAC_BITS_DEF;
          x = -(hz_py * k + hz_w0);
        end else begin
          x = $urandom;
          y = $urandom;
        end
      end
    endcase
    return {y, x};
  endfunction

  task automatic random_config(input cfg_style_t style);
    horizon_mode = 1'b0;
    case (style)
      CFG_FULL_RANDOM: begin
        for (int i = 0; i < NUM_REGS; i++) write_reg(CFG_IDX_W'(i), {any_coeff(), any_coeff()});
      end
      CFG_NEAR_AFFINE: begin
        write_reg(REG_SCALE_XX, {32'($urandom), UNITY + small_coeff()});
        write_reg(REG_SHEAR_YX, {32'($urandom), small_coeff()});
        write_reg(REG_OFFSET_X, {32'($urandom), any_coeff()});
        write_reg(REG_SHEAR_XY, {32'($urandom), small_coeff()});
        write_reg(REG_SCALE_YY, {32'($urandom), UNITY + small_coeff()});
        write_reg(REG_OFFSET_Y, {32'($urandom), any_coeff()});
        write_reg(REG_PROJECTIVE, {small_coeff() >>> 8, small_coeff() >>> 8});
        write_reg(REG_WEIGHT_OFFSET, {32'($urandom), UNITY + small_coeff()});
      end
      CFG_HORIZON: begin
        hz_py = int'($urandom_range(0, 2097152)) - 1048576;
        hz_w0 = int'($urandom_range(0, 2097152)) - 1048576;
        horizon_mode = 1'b1;
        write_reg(REG_SCALE_XX, {32'($urandom), any_coeff()});
        write_reg(REG_SHEAR_YX, {32'($urandom), any_coeff()});
        write_reg(REG_OFFSET_X, {32'($urandom), any_coeff()});
        write_reg(REG_SHEAR_XY, {32'($urandom), any_coeff()});
        write_reg(REG_SCALE_YY, {32'($urandom), any_coeff()});
        write_reg(REG_OFFSET_Y, {32'($urandom), any_coeff()});
        write_reg(REG_PROJECTIVE, {32'(hz_py), UNITY});
        write_reg(REG_WEIGHT_OFFSET, {32'($urandom), 32'(hz_w0)});
      end
      default: begin
        for (int i = 0; i < NUM_REGS; i++) begin
          if ($urandom_range(0, 1) == 1) write_reg(CFG_IDX_W'(i), {any_coeff(), any_coeff()});
        end
      end
    endcase
    if ($urandom_range(0, 2) == 0) begin
      write_reg(CFG_IDX_W'($urandom_range(NUM_REGS, (1 << CFG_IDX_W) - 1)),
                {32'($urandom), 32'($urandom)});
    end
    end_writes();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // identity transform out of reset
    queue_point('0, '0);
    queue_point(COORD_MAX, COORD_MIN);
    queue_point(COORD_MIN, COORD_MAX);
    queue_point(COORD_W'(1), '1);
    queue_point(3 * UNITY, -(5 * UNITY));
    wait_idle();

    // negative denominator, saturation both ways, writes beyond the register list
    write_reg(REG_WEIGHT_OFFSET, {32'($urandom), NEG_UNITY});
    write_reg(REG_BEYOND_FIRST, {32'($urandom), 32'($urandom)});
    write_reg(REG_BEYOND_LAST, {32'($urandom), 32'($urandom)});
    end_writes();
    queue_point(COORD_MIN, COORD_MAX);
    queue_point(COORD_MAX, COORD_MIN);
    queue_point('1, COORD_W'(1));
    wait_idle();

    // denominator x - 1.0: zero weight on x = 1.0, tiny weights around it
    write_reg(REG_PROJECTIVE, {32'd0, UNITY});
    write_reg(REG_SCALE_XX, {32'($urandom), 2 * UNITY});
    end_writes();
    queue_point(UNITY, 7 * UNITY);
    queue_point(UNITY, COORD_MIN);
    queue_point('0, '0);
    queue_point(UNITY + 1, COORD_W'(5));
    queue_point(UNITY - 1, -COORD_W'(3));
    queue_point(-COORD_W'(5), COORD_W'(3));
    wait_idle();

    // every register at its extremes
    for (int i = 0; i < NUM_REGS; i++) write_reg(CFG_IDX_W'(i), {COORD_MIN, COORD_MIN});
    end_writes();
    queue_point(COORD_MAX, COORD_MAX);
    queue_point(COORD_MIN, COORD_MIN);
    queue_point('0, '0);
    queue_point(COORD_W'(1), COORD_W'(1));
    wait_idle();
    for (int i = 0; i < NUM_REGS; i++) write_reg(CFG_IDX_W'(i), {COORD_MAX, COORD_MAX});
    end_writes();
    queue_point(COORD_MAX, COORD_MAX);
    queue_point(COORD_MIN, COORD_MIN);
    queue_point('0, '0);
    queue_point(COORD_W'(1), COORD_W'(1));
    wait_idle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      random_config(cfg_style_t'(p % 4));
      if (p == PRESSURE_PHASE) begin
        // receiver holds off while points keep coming
        no_gaps = 1'b1;
        hold_requests++;
      end
      repeat (POINTS_PER_PHASE) points_to_send.push_back(random_point());
      wait_idle();
      no_gaps = 1'b0;
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
